@@ rtl/core/rhc_pkg.sv @@
// shared types and constants of the rgb to hsv converter
// no dependencies; imported by every module of the block
package rhc_pkg;

  localparam int unsigned HUE_CIRCLE = 23040;
  localparam int unsigned HUE_SECTOR = 3840;
  localparam int unsigned HUE_GREEN  = 7680;
  localparam int unsigned HUE_BLUE   = 15360;
  localparam int unsigned SAT_ONE    = 65536;

  // divider geometry: rounded numerator, quotient and reciprocal widths
  localparam int unsigned NUM_W = 25;
  localparam int unsigned QUO_W = 17;
  localparam int unsigned RCP_W = 25;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [16:0] saturation;
    logic [7:0]  value;
    logic [7:0]  alpha_out;
  } hsv_t;

  // per-pixel sector data after the first stage
  typedef struct packed {
    logic [7:0]  value;
    logic [7:0]  delta;
    logic [7:0]  diff_mag;
    logic        neg;
    logic [14:0] base;
    logic [7:0]  alpha;
  } sect_t;

endpackage

@@ rtl/core/rhc_sector.sv @@
// first stage: max, min, delta and hue sector selection
// depends on rhc_pkg
module rhc_sector import rhc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  rgba_t pixel_i,
  output logic  valid_o,
  output sect_t sect_o
);

  logic [7:0] mx, mn, p, q;
  logic [14:0] base;
  sect_t sect_d, sect_q;
  logic valid_q;

  always_comb begin
    mx = pixel_i.red;
    mn = pixel_i.red;
    if (pixel_i.green > mx) mx = pixel_i.green;
    if (pixel_i.blue > mx) mx = pixel_i.blue;
    if (pixel_i.green < mn) mn = pixel_i.green;
    if (pixel_i.blue < mn) mn = pixel_i.blue;

    // first largest channel in red, green, blue order wins
    priority if (mx == pixel_i.red) begin
      p = pixel_i.green; q = pixel_i.blue; base = 15'd0;
    end else if (mx == pixel_i.green) begin
      p = pixel_i.blue; q = pixel_i.red; base = 15'(HUE_GREEN);
    end else begin
      p = pixel_i.red; q = pixel_i.green; base = 15'(HUE_BLUE);
    end

    sect_d.value    = mx;
    sect_d.delta    = mx - mn;
    sect_d.neg      = (p < q);
    sect_d.diff_mag = (p >= q) ? (p - q) : (q - p);
    sect_d.base     = base;
    sect_d.alpha    = pixel_i.alpha;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sect_q <= sect_d;
  end

  assign valid_o = valid_q;
  assign sect_o  = sect_q;

endmodule

@@ rtl/core/rhc_rdiv.sv @@
// three-stage rounded divider: floor(num / (2 * den)) by reciprocal table,
// multiply and one correction step; depends on rhc_pkg
module rhc_rdiv import rhc_pkg::*; (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [7:0]       den_i,
  output logic [QUO_W-1:0] quo_o
);

  // reciprocal table floor(2^24 / den), entry for zero unused
  logic [RCP_W-1:0] rcp_tab [256];

  for (genvar i = 0; i < 256; i++) begin : g_rcp
    localparam int unsigned Den = (i == 0) ? 1 : i;
    localparam logic [RCP_W-1:0] Rcp = (i == 0) ? '0 : RCP_W'((32'd1 << 24) / Den);
    assign rcp_tab[i] = Rcp;
  end

  logic [NUM_W-1:0]       num_a_q, num_b_q;
  logic [8:0]             den2_a_q, den2_b_q;
  logic [RCP_W-1:0]       rcp_a_q;
  logic [QUO_W-1:0]       q0_b_q, quo_c_q;
  logic [NUM_W+RCP_W-1:0] prod;
  logic [25:0]            qd;
  logic [26:0]            rem;
  logic [QUO_W-1:0]       quo_d;

  always_ff @(posedge clk_i) begin
    num_a_q  <= num_i;
    den2_a_q <= {den_i, 1'b0};
    rcp_a_q  <= rcp_tab[den_i];
  end

  // estimate is exact or one short
  assign prod = (NUM_W+RCP_W)'(num_a_q) * (NUM_W+RCP_W)'(rcp_a_q);

  always_ff @(posedge clk_i) begin
    q0_b_q   <= prod[25+QUO_W-1:25];
    num_b_q  <= num_a_q;
    den2_b_q <= den2_a_q;
  end

  always_comb begin
    qd    = 26'(q0_b_q) * 26'(den2_b_q);
    rem   = {2'b00, num_b_q} - {1'b0, qd};
    quo_d = q0_b_q + QUO_W'(rem >= {18'd0, den2_b_q});
  end

  always_ff @(posedge clk_i) begin
    quo_c_q <= quo_d;
  end

  assign quo_o = quo_c_q;

endmodule

@@ rtl/core/rhc_finish.sv @@
// last stage: hue from base and rounded offset with wrap, grey handling,
// output register and strobe; depends on rhc_pkg
module rhc_finish import rhc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  sect_t            sect_i,
  input  logic [QUO_W-1:0] sat_i,
  input  logic [QUO_W-1:0] mag_i,
  output logic             valid_o,
  output hsv_t             result_o
);

  logic [15:0] base16, mag16, hue16;
  hsv_t res_d, res_q;
  logic valid_q;

  always_comb begin
    base16 = 16'(sect_i.base);
    mag16  = 16'(mag_i[11:0]);
    priority if (sect_i.delta == 8'd0) begin
      hue16 = 16'd0;
    end else if (!sect_i.neg) begin
      hue16 = base16 + mag16;
    end else if (mag16 == 16'd0) begin
      hue16 = base16;
    end else if (base16 >= mag16) begin
      hue16 = base16 - mag16;
    end else begin
      // negative red-sector hue wraps round the circle
      hue16 = base16 + 16'(HUE_CIRCLE) - mag16;
    end

    res_d.hue        = hue16[14:0];
    res_d.saturation = (sect_i.delta == 8'd0) ? '0 : sat_i;
    res_d.value      = sect_i.value;
    res_d.alpha_out  = sect_i.alpha;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

@@ rtl/core/rgb_to_hsv_convert_unit.sv @@
// top level of the rgb to hsv converter: sector stage, two dividers, finish
// depends on rhc_pkg, rhc_sector, rhc_rdiv, rhc_finish
//
// channel  ports                      direction  transaction
// pixel    start, busy, pixel_i       in         start high and busy low at clk_i
// result   valid_o, result_o          out        valid_o high for one cycle
//
// one pixel per clock; valid_o follows an accepted start through the sector, divider and finish registers
// stages: sector select, table lookup, reciprocal multiply, correction, hue
// the multiply by the stored reciprocal sets the stage depth
// rst_ni clears the valid bits of every stage at once
// busy stays low: the receiver cannot stall, so nothing ever holds off input
module rgb_to_hsv_convert_unit import rhc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  rgba_t pixel_i,
  output logic  valid_o,
  output hsv_t  result_o
);

  logic             accept;
  logic             v1;
  sect_t            s1;
  logic [2:0]       vld_q;
  sect_t            side_q [3];
  logic [NUM_W-1:0] sat_num, hue_num;
  logic [QUO_W-1:0] sat_quo, hue_quo;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  rhc_sector u_sector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .pixel_i (pixel_i),
    .valid_o (v1),
    .sect_o  (s1)
  );

  // rounded numerators 2*scale*num + den
  assign sat_num = {s1.delta, 9'd0, s1.value};
  assign hue_num = NUM_W'(s1.diff_mag) * NUM_W'(2 * HUE_SECTOR) + NUM_W'(s1.delta);

  rhc_rdiv u_sat_div (
    .clk_i (clk_i),
    .num_i (sat_num),
    .den_i (s1.value),
    .quo_o (sat_quo)
  );

  rhc_rdiv u_hue_div (
    .clk_i (clk_i),
    .num_i (hue_num),
    .den_i (s1.delta),
    .quo_o (hue_quo)
  );

  // side data rides alongside the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], v1};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= s1;
    side_q[1] <= side_q[0];
    side_q[2] <= side_q[1];
  end

  rhc_finish u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vld_q[2]),
    .sect_i   (side_q[2]),
    .sat_i    (sat_quo),
    .mag_i    (hue_quo),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 valid_o)
    else $error("accepted pixel did not produce a result after five cycles");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, 5))
    else $error("result strobe without a matching accepted pixel");

  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (32'(result_o.hue) < HUE_CIRCLE) &&
                (32'(result_o.saturation) <= SAT_ONE))
    else $error("hue or saturation out of range");

  a_grey : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (result_o.saturation == '0) |-> (result_o.hue == '0))
    else $error("grey pixel with non-zero hue");

endmodule
